/* sv/hbs_pkg.sv */
// hbs_pkg: shared constants, codes and types of the heightmap bilinear sampler
// depends on nothing; imported by the top level and every hbs module but hbs_ram
package hbs_pkg;

  // height store geometry
  localparam int unsigned GRID_MAX_WIDTH  = 256;
  localparam int unsigned GRID_MAX_LENGTH = 256;
  localparam int unsigned COL_W           = $clog2(GRID_MAX_WIDTH);
  localparam int unsigned ROW_W           = $clog2(GRID_MAX_LENGTH);
  localparam int unsigned DIM_W           = 9;
  localparam int unsigned NUM_BANKS       = 4;
  localparam int unsigned BANK_DEPTH      = GRID_MAX_WIDTH * GRID_MAX_LENGTH / NUM_BANKS;
  localparam int unsigned BANK_AW         = $clog2(BANK_DEPTH);

  // field widths
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned RECIP_W  = 24;
  localparam int unsigned HPL_W    = 24;
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned FRAC_W   = 8;

  // configuration register reset values
  localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]   GRID_LENGTH_RST = DIM_W'(256);
  localparam logic [RECIP_W-1:0] RECIP_RST       = RECIP_W'(65536);
  localparam logic [HPL_W-1:0]   HPL_RST         = HPL_W'(257);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_LENGTH = 2'd1,
    REG_CELL_RECIP  = 2'd2,
    REG_HEIGHT_LVL  = 2'd3
  } reg_idx_e;

  // one classified item; a load carries its column and row in cx and cy
  typedef struct packed {
    cmd_e               cmd;
    logic               oob;
    logic [COL_W-1:0]   cx;
    logic [ROW_W-1:0]   cy;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [LEVEL_W-1:0] value;
  } hbs_item_t;

  typedef struct packed {
    logic empty;
    logic almost_full;
  } hbs_qstat_t;

endpackage

/* sv/heightmap_bilinear_sampler_core.sv */
// heightmap_bilinear_sampler_core: top level, register port, front, queue and back
// depends on hbs_pkg, hbs_front, hbs_queue, hbs_back (and hbs_ram below it)
// throughput: one item (load or query) per cycle while busy is low, set by the four-bank store read
// busy rises only if the queue nears full; the back drains one item a cycle, so it stays low
// reset clears the pipeline and restores register defaults; the height store is not cleared
module heightmap_bilinear_sampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [hbs_pkg::COL_W-1:0]     sample_col_i,
  input  logic [hbs_pkg::ROW_W-1:0]     sample_row_i,
  input  logic [hbs_pkg::LEVEL_W-1:0]   sample_value_i,
  input  logic signed [hbs_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [hbs_pkg::POS_W-1:0] pos_y_i,
  // result channel
  output logic                          result_valid_o,
  output logic [hbs_pkg::HEIGHT_W-1:0]  height_o,
  output logic                          out_of_bounds_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hbs_pkg::*;

  // configuration registers
  logic [DIM_W-1:0]   grid_width_q, grid_length_q;
  logic [RECIP_W-1:0] cell_recip_q;
  logic [HPL_W-1:0]   height_lvl_q;
  logic               cfg_wr;
  reg_idx_e           reg_idx;

  // internal links
  logic        accept;
  logic        push, pop;
  hbs_item_t   front_item, queue_item;
  hbs_qstat_t  qstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_length_q <= GRID_LENGTH_RST;
      cell_recip_q  <= RECIP_RST;
      height_lvl_q  <= HPL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[DIM_W-1:0];
        REG_GRID_LENGTH: grid_length_q <= pwdata[DIM_W-1:0];
        REG_CELL_RECIP:  cell_recip_q  <= pwdata[RECIP_W-1:0];
        REG_HEIGHT_LVL:  height_lvl_q  <= pwdata[HPL_W-1:0];
      endcase
    end
  end

  // read back, zero-extended to the bus
  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
      REG_GRID_LENGTH: prdata = 32'(grid_length_q);
      REG_CELL_RECIP:  prdata = 32'(cell_recip_q);
      REG_HEIGHT_LVL:  prdata = 32'(height_lvl_q);
    endcase
  end

  // a transfer is taken whenever the queue has room for it and the item in flight
  assign busy   = qstat.almost_full;
  assign accept = start && !busy;

  hbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (cmd_e'(command_i)),
    .sample_col_i   (sample_col_i),
    .sample_row_i   (sample_row_i),
    .sample_value_i (sample_value_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .grid_width_i   (grid_width_q),
    .grid_length_i  (grid_length_q),
    .cell_recip_i   (cell_recip_q),
    .push_o         (push),
    .item_o         (front_item)
  );

  hbs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (qstat)
  );

  // the back never stalls: it drains the queue head every cycle the queue is not empty
  assign pop = !qstat.empty;

  hbs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_i           (pop),
    .item_i          (queue_item),
    .height_lvl_i    (height_lvl_q),
    .result_valid_o  (result_valid_o),
    .height_o        (height_o),
    .out_of_bounds_o (out_of_bounds_o)
  );

  // assertions
  logic query_taken;
  assign query_taken = accept && (command_i == CMD_QUERY);

  a_query_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_taken |-> ##6 result_valid_o)
    else $error("query transfer without result");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(query_taken, 6))
    else $error("result without query transfer");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && out_of_bounds_o |-> height_o == '0)
    else $error("out-of-bounds result with nonzero height");

endmodule

/* sv/hbs_ram.sv */
// hbs_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module hbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/hbs_front.sv */
// hbs_front: accepts items, scales query positions to grid units and classifies them
// depends on hbs_pkg
module hbs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  hbs_pkg::cmd_e                 command_i,
  input  logic [hbs_pkg::COL_W-1:0]     sample_col_i,
  input  logic [hbs_pkg::ROW_W-1:0]     sample_row_i,
  input  logic [hbs_pkg::LEVEL_W-1:0]   sample_value_i,
  input  logic signed [hbs_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [hbs_pkg::POS_W-1:0] pos_y_i,
  input  logic [hbs_pkg::DIM_W-1:0]     grid_width_i,
  input  logic [hbs_pkg::DIM_W-1:0]     grid_length_i,
  input  logic [hbs_pkg::RECIP_W-1:0]   cell_recip_i,
  output logic                          push_o,
  output hbs_pkg::hbs_item_t            item_o
);
  import hbs_pkg::*;

  localparam int unsigned PROD_W = POS_W + RECIP_W + 1;
  localparam int unsigned CELL_W = PROD_W - 1 - 16 - FRAC_W;

  logic                      valid_q;
  cmd_e                      cmd_q;
  logic [COL_W-1:0]          col_q;
  logic [ROW_W-1:0]          row_q;
  logic [LEVEL_W-1:0]        value_q;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q;

  logic [CELL_W-1:0]  cell_x, cell_y;
  logic [DIM_W-1:0]   w_eff, l_eff;
  logic               oob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  // q16.8 position times q8.16 reciprocal gives q.24 grid units
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q    <= command_i;
      col_q    <= sample_col_i;
      row_q    <= sample_row_i;
      value_q  <= sample_value_i;
      prod_x_q <= PROD_W'(pos_x_i) * $signed({1'b0, cell_recip_i});
      prod_y_q <= PROD_W'(pos_y_i) * $signed({1'b0, cell_recip_i});
    end
  end

  assign cell_x = prod_x_q[PROD_W-2 -: CELL_W];
  assign cell_y = prod_y_q[PROD_W-2 -: CELL_W];
  assign w_eff  = (grid_width_i  > DIM_W'(GRID_MAX_WIDTH))  ? DIM_W'(GRID_MAX_WIDTH)  : grid_width_i;
  assign l_eff  = (grid_length_i > DIM_W'(GRID_MAX_LENGTH)) ? DIM_W'(GRID_MAX_LENGTH) : grid_length_i;

  // negative coordinate or no right or lower neighbor
  assign oob = prod_x_q[PROD_W-1] || prod_y_q[PROD_W-1]
            || ((CELL_W+1)'(cell_x) + (CELL_W+1)'(1) >= (CELL_W+1)'(w_eff))
            || ((CELL_W+1)'(cell_y) + (CELL_W+1)'(1) >= (CELL_W+1)'(l_eff));

  always_comb begin
    item_o       = '0;
    item_o.cmd   = cmd_q;
    item_o.value = value_q;
    if (cmd_q == CMD_QUERY) begin
      item_o.oob = oob;
      item_o.cx  = cell_x[COL_W-1:0];
      item_o.cy  = cell_y[ROW_W-1:0];
      item_o.fx  = prod_x_q[16 +: FRAC_W];
      item_o.fy  = prod_y_q[16 +: FRAC_W];
    end else begin
      item_o.cx = col_q;
      item_o.cy = row_q;
    end
  end

  assign push_o = valid_q;

endmodule

/* sv/hbs_queue.sv */
// hbs_queue: short fifo of classified items between front and back
// depends on hbs_pkg
module hbs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hbs_pkg::hbs_item_t  item_i,
  input  logic                pop_i,
  output hbs_pkg::hbs_item_t  item_o,
  output hbs_pkg::hbs_qstat_t status_o
);
  import hbs_pkg::*;

  hbs_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  assign item_o               = slot_q[rptr_q];
  assign status_o.empty       = (count_q == '0);
  // one slot held back for the item already inside the front stage
  assign status_o.almost_full = (count_q >= (QPTR_W+1)'(QUEUE_DEPTH - 1));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue underflow");

endmodule

/* sv/hbs_back.sv */
// hbs_back: banked height store, bilinear blend and height scaling
// depends on hbs_pkg and hbs_ram
module hbs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_i,
  input  hbs_pkg::hbs_item_t           item_i,
  input  logic [hbs_pkg::HPL_W-1:0]    height_lvl_i,
  output logic                         result_valid_o,
  output logic [hbs_pkg::HEIGHT_W-1:0] height_o,
  output logic                         out_of_bounds_o
);
  import hbs_pkg::*;

  localparam int unsigned WT_W    = FRAC_W + 1;
  localparam int unsigned ROWB_W  = LEVEL_W + FRAC_W;
  localparam int unsigned BLEND_W = ROWB_W + FRAC_W;
  localparam int unsigned PROD_W  = BLEND_W + HPL_W;

  logic [COL_W-1:0]   cx1;
  logic [ROW_W-1:0]   cy1;
  logic [LEVEL_W-1:0] rdata [NUM_BANKS];

  // stage 1: store access
  logic       s1_valid_q;
  hbs_item_t  s1_q;
  // stage 2: row blends
  logic               s2_valid_q, s2_oob_q;
  logic [FRAC_W-1:0]  s2_fy_q;
  logic [ROWB_W-1:0]  s2_top_q, s2_bot_q;
  // stage 3: column blend
  logic               s3_valid_q, s3_oob_q;
  logic [BLEND_W-1:0] s3_blend_q;
  // output
  logic                s4_valid_q, s4_oob_q;
  logic [HEIGHT_W-1:0] s4_height_q;

  assign cx1 = item_i.cx + COL_W'(1);
  assign cy1 = item_i.cy + ROW_W'(1);

  // bank = {row parity, col parity}: the four corners always hit four banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [COL_W-1:0] col_sel;
    logic [ROW_W-1:0] row_sel;
    logic             we;

    assign col_sel = (item_i.cx[0] == 1'(b)) ? item_i.cx : cx1;
    assign row_sel = (item_i.cy[0] == 1'(b >> 1)) ? item_i.cy : cy1;
    assign we      = pop_i && (item_i.cmd == CMD_LOAD)
                  && ({item_i.cy[0], item_i.cx[0]} == 2'(b));

    hbs_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i ({item_i.cy[ROW_W-1:1], item_i.cx[COL_W-1:1]}),
      .wdata_i (item_i.value),
      .re_i    (pop_i && (item_i.cmd == CMD_QUERY)),
      .raddr_i ({row_sel[ROW_W-1:1], col_sel[COL_W-1:1]}),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    s1_q <= item_i;
  end

  // corner unscramble, row blends, column blend and height scaling
  logic [LEVEL_W-1:0] c00, c10, c01, c11;
  logic [WT_W-1:0]    wx0, wx1, wy0, wy1;
  logic [ROWB_W:0]    top_full, bot_full;
  logic [BLEND_W+1:0] blend_full;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    c00 = rdata[{s1_q.cy[0],  s1_q.cx[0]}];
    c10 = rdata[{s1_q.cy[0], ~s1_q.cx[0]}];
    c01 = rdata[{~s1_q.cy[0],  s1_q.cx[0]}];
    c11 = rdata[{~s1_q.cy[0], ~s1_q.cx[0]}];
    wx1 = WT_W'(s1_q.fx);
    wx0 = WT_W'(1 << FRAC_W) - wx1;
    top_full = (ROWB_W+1)'(c00) * (ROWB_W+1)'(wx0)
             + (ROWB_W+1)'(c10) * (ROWB_W+1)'(wx1);
    bot_full = (ROWB_W+1)'(c01) * (ROWB_W+1)'(wx0)
             + (ROWB_W+1)'(c11) * (ROWB_W+1)'(wx1);
    wy1 = WT_W'(s2_fy_q);
    wy0 = WT_W'(1 << FRAC_W) - wy1;
    blend_full = (BLEND_W+2)'(s2_top_q) * (BLEND_W+2)'(wy0)
               + (BLEND_W+2)'(s2_bot_q) * (BLEND_W+2)'(wy1);
    // blend stays below 2^24 and hpl below 2^24, so the q16.16 result fits 32 bits
    prod = PROD_W'(s3_blend_q) * PROD_W'(height_lvl_i);
  end

  always_ff @(posedge clk_i) begin
    s2_oob_q    <= s1_q.oob;
    s2_fy_q     <= s1_q.fy;
    s2_top_q    <= top_full[ROWB_W-1:0];
    s2_bot_q    <= bot_full[ROWB_W-1:0];
    s3_oob_q    <= s2_oob_q;
    s3_blend_q  <= blend_full[BLEND_W-1:0];
    s4_oob_q    <= s3_oob_q;
    s4_height_q <= s3_oob_q ? '0 : prod[16 +: HEIGHT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pop_i && (item_i.cmd == CMD_QUERY);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  assign result_valid_o  = s4_valid_q;
  assign height_o        = s4_height_q;
  assign out_of_bounds_o = s4_oob_q;

endmodule

/* bench/tb_heightmap_bilinear_sampler_core.sv */
// tb_heightmap_bilinear_sampler_core: self-checking bench for the bilinear height sampler
// depends on hbs_pkg and heightmap_bilinear_sampler_core; a local predictor checks every height
// loads, queries and register transfers; directed corner cases, then random traffic with and without idling
module tb_heightmap_bilinear_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hbs_pkg::*;

  // generous run limit and the settle time after the last result
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned STORE_DEPTH  = GRID_MAX_WIDTH * GRID_MAX_LENGTH;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                oob;
  } sample_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic                      command_i;
  logic [COL_W-1:0]          sample_col_i;
  logic [ROW_W-1:0]          sample_row_i;
  logic [LEVEL_W-1:0]        sample_value_i;
  logic signed [POS_W-1:0]   pos_x_i;
  logic signed [POS_W-1:0]   pos_y_i;
  logic                      result_valid_o;
  logic [HEIGHT_W-1:0]       height_o;
  logic                      out_of_bounds_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [3:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  // shadow of the height store; loaded marks entries a query may read
  logic [LEVEL_W-1:0] level_shadow [STORE_DEPTH];
  bit                 loaded [STORE_DEPTH];

  // shadow of the configuration registers
  logic [DIM_W-1:0]   cfg_width;
  logic [DIM_W-1:0]   cfg_length;
  logic [RECIP_W-1:0] cfg_recip;
  logic [HPL_W-1:0]   cfg_hpl;

  // heights still owed by the block, oldest first
  sample_result_t pending_heights [$];

  int          idle_pct;
  int          errors;
  int unsigned cycle_count;
  int unsigned items_sent;

  heightmap_bilinear_sampler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .sample_col_i   (sample_col_i),
    .sample_row_i   (sample_row_i),
    .sample_value_i (sample_value_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .result_valid_o (result_valid_o),
    .height_o       (height_o),
    .out_of_bounds_o(out_of_bounds_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // watchdog: a hung handshake or a missing result ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // scale a position to grid units and find its cell; 0 when no interpolable cell
  function automatic bit grid_cell(input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] py,
                                   output int unsigned cx, output int unsigned cy,
                                   output int unsigned fx, output int unsigned fy);
    longint gx;
    longint gy;
    longint dim_w;
    longint dim_l;
    cx = 0;
    cy = 0;
    fx = 0;
    fy = 0;
    // signed Q16.8 times unsigned Q8.16 gives Q.24, keep 8 fraction bits
    gx = longint'(px) * longint'(cfg_recip);
    gy = longint'(py) * longint'(cfg_recip);
    if (gx < 0 || gy < 0) return 1'b0;
    gx = gx >> 16;
    gy = gy >> 16;
    // size registers above the store size act as the store size
    dim_w = (cfg_width > GRID_MAX_WIDTH) ? GRID_MAX_WIDTH : cfg_width;
    dim_l = (cfg_length > GRID_MAX_LENGTH) ? GRID_MAX_LENGTH : cfg_length;
    if ((gx >> 8) + 1 >= dim_w || (gy >> 8) + 1 >= dim_l) return 1'b0;
    cx = int'(gx >> 8);
    cy = int'(gy >> 8);
    fx = int'(gx & 255);
    fy = int'(gy & 255);
    return 1'b1;
  endfunction

  function automatic longint unsigned level_at(input int unsigned col, input int unsigned row);
    return longint'(level_shadow[row * GRID_MAX_WIDTH + col]);
  endfunction

  // expected result of one query against the shadow store and registers
  function automatic sample_result_t predict_height(input logic signed [POS_W-1:0] px,
                                                    input logic signed [POS_W-1:0] py);
    int unsigned       cx, cy, fx, fy;
    longint unsigned   top, bot, blend, h;
    sample_result_t    r;
    r.height = '0;
    r.oob    = 1'b1;
    if (!grid_cell(px, py, cx, cy, fx, fy)) return r;
    top   = level_at(cx, cy) * (256 - fx) + level_at(cx + 1, cy) * fx;
    bot   = level_at(cx, cy + 1) * (256 - fx) + level_at(cx + 1, cy + 1) * fx;
    // blend in Q8.16 levels, then scale to Q16.16 world height, truncated
    blend = top * (256 - fy) + bot * fy;
    h     = (blend * longint'(cfg_hpl)) >> 16;
    if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
    r.height = h[HEIGHT_W-1:0];
    r.oob    = 1'b0;
    return r;
  endfunction

  // position aimed at the grid in use: mostly inside, some negative, some anywhere
  function automatic logic signed [POS_W-1:0] aim_position(input int unsigned cells);
    longint unsigned target;
    longint unsigned pos;
    int unsigned     roll;
    roll = $urandom_range(99);
    if (roll < 10 || cfg_recip == 0) return POS_W'($urandom);
    target = longint'($urandom_range(cells * 256 + 255));
    pos    = (target << 16) / cfg_recip;
    if (pos > 64'h7F_FFFF) pos = 64'h7F_FFFF;
    // bitwise inverse of a non-negative value is always negative
    if (roll < 16) return POS_W'(~pos);
    return POS_W'(pos);
  endfunction

  // one command transfer; start stays high when the next item follows at once
  task automatic send_item(input cmd_e cmd, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] value,
                           input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py);
    int unsigned addr;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    command_i      <= cmd;
    sample_col_i   <= col;
    sample_row_i   <= row;
    sample_value_i <= value;
    pos_x_i        <= px;
    pos_y_i        <= py;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    // transfer taken at this edge; update the shadow in item order
    if (cmd == CMD_LOAD) begin
      addr = row * GRID_MAX_WIDTH + col;
      level_shadow[addr] = value;
      loaded[addr]       = 1'b1;
    end else begin
      pending_heights.push_back(predict_height(px, py));
    end
  endtask

  // load ignores the position fields, so they carry noise
  task automatic load_level(input int unsigned col, input int unsigned row,
                            input int unsigned value);
    send_item(CMD_LOAD, COL_W'(col), ROW_W'(row), LEVEL_W'(value),
              POS_W'($urandom), POS_W'($urandom));
  endtask

  // query that first loads any corner it would read but that was never loaded
  task automatic issue_query(input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py);
    int unsigned cx, cy, fx, fy;
    if (grid_cell(px, py, cx, cy, fx, fy)) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!loaded[(cy + dy) * GRID_MAX_WIDTH + cx + dx]) begin
            load_level(cx + dx, cy + dy, $urandom_range(255));
          end
        end
      end
    end
    send_item(CMD_QUERY, COL_W'($urandom), ROW_W'($urandom), LEVEL_W'($urandom), px, py);
  endtask

  // stop sending, wait for every owed result, then let trailing loads retire
  task automatic quiesce();
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register transfer: setup cycle, then access until pready
  task automatic apb_transfer(input reg_idx_e idx, input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write a register, mirror it, and read it back
  task automatic set_register(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] stored;
    apb_transfer(idx, 1'b1, value, readback);
    case (idx)
      REG_GRID_WIDTH: begin
        cfg_width = value[DIM_W-1:0];
        stored    = 32'(cfg_width);
      end
      REG_GRID_LENGTH: begin
        cfg_length = value[DIM_W-1:0];
        stored     = 32'(cfg_length);
      end
      REG_CELL_RECIP: begin
        cfg_recip = value[RECIP_W-1:0];
        stored    = 32'(cfg_recip);
      end
      default: begin
        cfg_hpl = value[HPL_W-1:0];
        stored  = 32'(cfg_hpl);
      end
    endcase
    apb_transfer(idx, 1'b0, '0, readback);
    if (readback !== stored) begin
      $error("register %s: expected %h, actual %h", idx.name(), stored, readback);
      errors++;
    end
  endtask

  // registers change only with the block idle
  task automatic set_config(input int unsigned width, input int unsigned length,
                            input int unsigned recip, input int unsigned hpl);
    quiesce();
    set_register(REG_GRID_WIDTH, width);
    set_register(REG_GRID_LENGTH, length);
    set_register(REG_CELL_RECIP, recip);
    set_register(REG_HEIGHT_LVL, hpl);
  endtask

  // compare each result strobe with the oldest owed height
  always @(posedge clk_i) begin
    sample_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_heights.size() == 0) begin
        $error("result with nothing owed: height %h out_of_bounds %b",
               height_o, out_of_bounds_o);
        errors++;
      end else begin
        want = pending_heights.pop_front();
        if (height_o !== want.height) begin
          $error("height: expected %h, actual %h", want.height, height_o);
          errors++;
        end
        if (out_of_bounds_o !== want.oob) begin
          $error("out_of_bounds: expected %b, actual %b", want.oob, out_of_bounds_o);
          errors++;
        end
      end
    end
  end

  // exact corners, full fraction, mid cell, last cell and just past it
  task automatic test_cell_corners();
    idle_pct = 0;
    set_config(256, 256, 65536, 257);
    load_level(0, 0, 0);
    load_level(1, 0, 255);
    load_level(0, 1, 255);
    load_level(1, 1, 0);
    issue_query(0, 0);
    issue_query(24'h0000FF, 24'h0000FF);
    issue_query(24'h000080, 24'h000080);
    load_level(254, 254, 255);
    load_level(255, 254, 255);
    load_level(254, 255, 255);
    load_level(255, 255, 255);
    issue_query(254 * 256 + 255, 254 * 256 + 255);
    issue_query(255 * 256, 0);
  endtask

  // negative and extreme positions
  task automatic test_position_extremes();
    issue_query(-1, 0);
    issue_query(24'sh800000, 24'sh7FFFFF);
    issue_query(24'sh7FFFFF, 0);
  endtask

  // zero and largest height per level
  task automatic test_height_scale();
    set_config(256, 256, 65536, 0);
    issue_query(24'h000080, 24'h000080);
    set_config(256, 256, 65536, 24'hFFFFFF);
    issue_query(254 * 256 + 17, 254 * 256 + 200);
  endtask

  // sizes too small for a cell, sizes above the store, smallest usable grid
  task automatic test_grid_size();
    set_config(1, 256, 65536, 257);
    issue_query(0, 0);
    set_config(511, 0, 65536, 257);
    issue_query(0, 0);
    set_config(511, 511, 65536, 257);
    issue_query(254 * 256 + 3, 254 * 256 + 250);
    set_config(2, 2, 65536, 257);
    issue_query(24'h000080, 24'h000040);
    issue_query(24'h000100, 0);
  endtask

  // zero reciprocal maps everything to cell zero; extreme reciprocals too
  task automatic test_cell_recip();
    set_config(256, 256, 0, 257);
    issue_query(24'sh800000, 24'sh7FFFFF);
    set_config(256, 256, 24'hFFFFFF, 257);
    issue_query(24'sh7FFFFF, 0);
    set_config(256, 256, 1, 257);
    issue_query(24'sh7FFFFF, 24'sh7FFFFF);
  endtask

  // random loads and queries over several register settings and idling phases
  task automatic test_random_traffic();
    int          pct [4];
    int unsigned dim_w, dim_l;
    int unsigned phase_end;
    pct = '{0, 57, 0, 15};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(256, 256, 65536, 257);
        1: set_config($urandom_range(40, 2), $urandom_range(40, 2),
                      $urandom_range(24'hFFFFFF, 1), $urandom_range(24'hFFFFFF));
        2: set_config(2, 256, $urandom_range(1 << 20, 1 << 12), 24'hFFFFFF);
        default: set_config($urandom_range(511), $urandom_range(511),
                            $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF));
      endcase
      idle_pct = pct[phase];
      dim_w = (cfg_width > GRID_MAX_WIDTH) ? GRID_MAX_WIDTH : cfg_width;
      dim_l = (cfg_length > GRID_MAX_LENGTH) ? GRID_MAX_LENGTH : cfg_length;
      // corner loads count toward the phase budget
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 15) begin
          // stray load that may overwrite a corner already in use
          load_level($urandom_range(255), $urandom_range(255), $urandom_range(255));
        end else begin
          issue_query(aim_position(dim_w), aim_position(dim_l));
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = CMD_LOAD;
    sample_col_i   = '0;
    sample_row_i   = '0;
    sample_value_i = '0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_width      = GRID_WIDTH_RST;
    cfg_length     = GRID_LENGTH_RST;
    cfg_recip      = RECIP_RST;
    cfg_hpl        = HPL_RST;
    idle_pct       = 0;
    errors         = 0;
    cycle_count    = 0;
    items_sent     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cell_corners();
    test_position_extremes();
    test_height_scale();
    test_grid_size();
    test_cell_recip();
    test_random_traffic();

    quiesce();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
sv/hbs_pkg.sv
sv/hbs_ram.sv
sv/hbs_front.sv
sv/hbs_queue.sv
sv/hbs_back.sv
sv/heightmap_bilinear_sampler_core.sv
bench/tb_heightmap_bilinear_sampler_core.sv
